@@ rtl/fscc_pkg.sv @@
// ----------------------------------------------------------------------------
// fscc_pkg
// Types, codes and constants shared by the fan curve controller files.
// ----------------------------------------------------------------------------
package fscc_pkg;

  // Fixed fan curve constants
  localparam int TABLE_ENTRIES = 10;
  localparam int FULL_SPEED    = 100;
  localparam int RPM_W         = 22;
  localparam logic [RPM_W-1:0] RPM_NUMERATOR = 22'd2156220;
  localparam int DIV_STEPS     = RPM_W;
  localparam int CNT_W         = $clog2(DIV_STEPS);
  localparam int CFG_W         = 40;

  // floor(x / 100) == (x * 5243) >> 19 for x <= 25500
  localparam logic [12:0] DUTY_RECIP = 13'd5243;
  localparam int          DUTY_SHIFT = 19;

  // control_mode codes; 5 to 7 act as full speed
  localparam logic [2:0] MODE_STEP   = 3'd0;
  localparam logic [2:0] MODE_TABLE  = 3'd1;
  localparam logic [2:0] MODE_STATIC = 3'd2;
  localparam logic [2:0] MODE_FULL   = 3'd3;
  localparam logic [2:0] MODE_AUTO   = 3'd4;

  // register indexes on the config port
  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_STATIC      = 3'd1,
    REG_LIMIT       = 3'd2,
    REG_STEP_PARAMS = 3'd3,
    REG_TEMP_LO     = 3'd4,
    REG_TEMP_HI     = 3'd5,
    REG_SPEED_LO    = 3'd6,
    REG_SPEED_HI    = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [2:0]       RST_MODE        = MODE_STEP;
  localparam logic [6:0]       RST_STATIC      = 7'd80;
  localparam logic [6:0]       RST_LIMIT       = 7'd100;
  localparam logic [CFG_W-1:0] RST_STEP_PARAMS = 40'd349564436485;
  localparam logic [CFG_W-1:0] RST_TEMP_LO     = 40'd297574653754;
  localparam logic [CFG_W-1:0] RST_TEMP_HI     = 40'd344555865414;
  localparam logic [CFG_W-1:0] RST_SPEED_LO    = 40'd171935700244;
  localparam logic [CFG_W-1:0] RST_SPEED_HI    = 40'd430014324284;

  typedef struct packed {
    logic [7:0]  temperature;
    logic [15:0] tach_count;
  } in_word_t;

  typedef struct packed {
    logic             duty_write;
    logic             auto_write;
    logic [7:0]       duty_value;
    logic [6:0]       reported_speed;
    logic             in_auto;
    logic [RPM_W-1:0] fan_rpm;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // speed percent -> duty byte, speed * 255 / 100
  function automatic logic [7:0] duty_of(logic [6:0] speed);
    logic [14:0] prod;
    logic [27:0] scaled;
    prod   = {speed, 8'b0} - {8'b0, speed};
    scaled = 28'(prod) * 28'(DUTY_RECIP);
    return scaled[DUTY_SHIFT+7:DUTY_SHIFT];
  endfunction

endpackage

@@ rtl/fan_speed_curve_controller_top.sv @@
// ----------------------------------------------------------------------------
// fan_speed_curve_controller_top
// Fan speed curve controller for one fan channel.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one word per control tick with
//    the sensor temperature and the tach period count.
//  - Output channel (out_valid/out_ready/out_data): exactly one word per input
//    word, in order: duty write flag and byte, auto release flag, commanded
//    speed, auto status and fan rpm.
//  - Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes,
//    no read-back; write only while no tick is in flight.
//  - Sequence: once the input word is taken, the curve target is computed,
//    the one-bit-per-cycle rpm divider runs, and the result is loaded into
//    the output register as soon as that register is free.
//  - One item is worked at a time; in_ready drops at accept and rises when
//    the result enters the output register.
//  - A stalled receiver holds the result in the output register; the next
//    input word can still be taken and worked, and its result waits in the
//    datapath until the register frees up.
//  - Reset (synchronous, active high) restores all config registers to their
//    defaults, clears commanded speed and auto status, and empties the output.
// ----------------------------------------------------------------------------
module fan_speed_curve_controller_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [fscc_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fscc_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fscc_pkg::out_word_t        out_data
);

  // sequencer commands to the datapath
  fscc_pkg::dp_cmd_t cmd;

  fscc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // curve target, speed state, rpm divider and output register
  fscc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

@@ rtl/fscc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fscc_ctrl
// Sequencer: capture, target update, rpm division steps, result handoff.
// ----------------------------------------------------------------------------
module fscc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fscc_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_OUT
  } state_t;

  state_t                     state;
  logic [fscc_pkg::CNT_W-1:0] cnt;
  logic                       slot_free;

  assign slot_free    = !out_valid || out_ready;
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.calc     = (state == S_CALC);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.load_out = (state == S_OUT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // new word into the output register, else drop it once taken
      if ((state == S_OUT) && slot_free) out_valid <= 1'b1;
      else if (out_valid && out_ready)   out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == fscc_pkg::CNT_W'(fscc_pkg::DIV_STEPS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/fscc_datapath.sv @@
// ----------------------------------------------------------------------------
// fscc_datapath
// Config registers, speed state, curve target logic, restoring rpm divider
// and the result register.
// ----------------------------------------------------------------------------
module fscc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [fscc_pkg::CFG_W-1:0]  cfg_data,
  input  fscc_pkg::in_word_t          in_data,
  input  fscc_pkg::dp_cmd_t           cmd,
  output fscc_pkg::out_word_t         out_data
);

  localparam int N = fscc_pkg::TABLE_ENTRIES;
  localparam int W = fscc_pkg::RPM_W;

  // config
  logic [2:0]                 control_mode;
  logic [6:0]                 static_speed;
  logic [6:0]                 speed_limit;
  logic [fscc_pkg::CFG_W-1:0] step_params;
  logic [fscc_pkg::CFG_W-1:0] temp_table_lo;
  logic [fscc_pkg::CFG_W-1:0] temp_table_hi;
  logic [fscc_pkg::CFG_W-1:0] speed_table_lo;
  logic [fscc_pkg::CFG_W-1:0] speed_table_hi;

  // state
  logic [6:0] current_speed;
  logic       auto_active;

  // captured item
  logic [7:0]  temp_q;
  logic [15:0] tach_q;

  // per-item result
  logic       res_duty_write;
  logic       res_auto_write;
  logic [6:0] res_speed;
  logic       res_in_auto;

  // divider
  logic [W-1:0] num_sh;
  logic [15:0]  rem;
  logic [W-1:0] quo;
  logic [16:0]  rem_sh;
  logic         fits;

  // target logic
  logic [7:0]        thr [N];
  logic [7:0]        spd [N];
  logic [7:0]        tab_sel;
  logic signed [9:0] step_raw;
  logic [6:0]        step_tgt;
  logic [6:0]        tab_tgt;
  logic [6:0]        static_tgt;
  logic [6:0]        target;
  logic              have_target;
  logic              speed_change;
  logic [6:0]        speed_next;

  wire [7:0] max_temp   = step_params[7:0];
  wire [7:0] min_temp   = step_params[15:8];
  wire [7:0] min_speed  = step_params[23:16];
  wire [7:0] step_size  = step_params[31:24];
  wire [7:0] min_safe   = step_params[39:32];

  // raise to both floors, then cap at full speed and at the limit
  function automatic logic [6:0] clamp_curve(logic signed [9:0] v, logic [7:0] fa,
                                             logic [7:0] fb, logic [6:0] lim);
    logic signed [9:0] w;
    w = v;
    if (w < $signed({2'b0, fa})) w = $signed({2'b0, fa});
    if (w < $signed({2'b0, fb})) w = $signed({2'b0, fb});
    if (w > 10'sd100) w = 10'sd100;
    if (w > $signed({3'b0, lim})) w = $signed({3'b0, lim});
    return w[6:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode   <= fscc_pkg::RST_MODE;
      static_speed   <= fscc_pkg::RST_STATIC;
      speed_limit    <= fscc_pkg::RST_LIMIT;
      step_params    <= fscc_pkg::RST_STEP_PARAMS;
      temp_table_lo  <= fscc_pkg::RST_TEMP_LO;
      temp_table_hi  <= fscc_pkg::RST_TEMP_HI;
      speed_table_lo <= fscc_pkg::RST_SPEED_LO;
      speed_table_hi <= fscc_pkg::RST_SPEED_HI;
    end else if (cfg_we) begin
      case (fscc_pkg::cfg_reg_t'(cfg_index))
        fscc_pkg::REG_MODE:        control_mode   <= cfg_data[2:0];
        fscc_pkg::REG_STATIC:      static_speed   <= cfg_data[6:0];
        fscc_pkg::REG_LIMIT:       speed_limit    <= cfg_data[6:0];
        fscc_pkg::REG_STEP_PARAMS: step_params    <= cfg_data;
        fscc_pkg::REG_TEMP_LO:     temp_table_lo  <= cfg_data;
        fscc_pkg::REG_TEMP_HI:     temp_table_hi  <= cfg_data;
        fscc_pkg::REG_SPEED_LO:    speed_table_lo <= cfg_data;
        fscc_pkg::REG_SPEED_HI:    speed_table_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack table bytes
  for (genvar g = 0; g < N; g++) begin : g_tab
    if (g < 5) begin : g_lo
      assign thr[g] = temp_table_lo[8*g +: 8];
      assign spd[g] = speed_table_lo[8*g +: 8];
    end else begin : g_hi
      assign thr[g] = temp_table_hi[8*(g-5) +: 8];
      assign spd[g] = speed_table_hi[8*(g-5) +: 8];
    end
  end

  // first band that holds the temperature wins; scan from the top down
  always_comb begin
    tab_sel = spd[N-1];
    for (int i = N - 2; i >= 0; i--) begin
      if (temp_q >= thr[i] && temp_q < thr[i+1]) tab_sel = spd[i];
    end
    if (temp_q < thr[0]) tab_sel = spd[0];
  end

  always_comb begin
    step_raw = $signed({3'b0, current_speed});
    if (temp_q > max_temp)      step_raw = step_raw + $signed({2'b0, step_size});
    else if (temp_q < min_temp) step_raw = step_raw - $signed({2'b0, step_size});
    step_tgt   = clamp_curve(step_raw, min_safe, min_speed, speed_limit);
    tab_tgt    = clamp_curve($signed({2'b0, tab_sel}), min_safe, 8'd0, speed_limit);
    static_tgt = (static_speed > 7'(fscc_pkg::FULL_SPEED)) ? 7'(fscc_pkg::FULL_SPEED)
                                                             : static_speed;
    have_target = 1'b1;
    case (control_mode)
      fscc_pkg::MODE_STEP:   target = step_tgt;
      fscc_pkg::MODE_TABLE:  target = tab_tgt;
      fscc_pkg::MODE_STATIC: target = static_tgt;
      fscc_pkg::MODE_AUTO: begin
        target      = current_speed;
        have_target = 1'b0;
      end
      default:               target = 7'(fscc_pkg::FULL_SPEED);
    endcase
    speed_change = have_target && (target != current_speed);
    speed_next   = speed_change ? target : current_speed;
  end

  // speed state; a stopped fan drops the commanded speed after the tick
  always_ff @(posedge clk) begin
    if (rst) begin
      current_speed <= '0;
      auto_active   <= 1'b0;
    end else if (cmd.calc) begin
      current_speed <= (tach_q == 16'd0) ? 7'd0 : speed_next;
      auto_active   <= (control_mode == fscc_pkg::MODE_AUTO);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res_duty_write <= speed_change;
      res_auto_write <= (control_mode == fscc_pkg::MODE_AUTO) && !auto_active;
      res_speed      <= speed_next;
      res_in_auto    <= (control_mode == fscc_pkg::MODE_AUTO);
    end
  end

  // restoring division of the rpm constant by the tach count, one bit a step
  assign rem_sh = {rem, num_sh[W-1]};
  assign fits   = (rem_sh >= {1'b0, tach_q});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      temp_q <= in_data.temperature;
      tach_q <= in_data.tach_count;
      num_sh <= fscc_pkg::RPM_NUMERATOR;
      rem    <= '0;
      quo    <= '0;
    end else if (cmd.div_step) begin
      num_sh <= {num_sh[W-2:0], 1'b0};
      rem    <= fits ? 16'(rem_sh - {1'b0, tach_q}) : rem_sh[15:0];
      quo    <= {quo[W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.duty_write     <= res_duty_write;
      out_data.auto_write     <= res_auto_write;
      out_data.duty_value     <= res_duty_write ? fscc_pkg::duty_of(res_speed) : 8'd0;
      out_data.reported_speed <= res_speed;
      out_data.in_auto        <= res_in_auto;
      out_data.fan_rpm        <= (tach_q == 16'd0) ? '0 : quo;
    end
  end

endmodule

@@ rtl/fscc_checker.sv @@
// ----------------------------------------------------------------------------
// fscc_checker
// Port-level checks for the fan curve controller, bound to the top level.
// ----------------------------------------------------------------------------
module fscc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_we,
  input logic [2:0]                 cfg_index,
  input logic [fscc_pkg::CFG_W-1:0] cfg_data,
  input logic                       in_valid,
  input logic                       in_ready,
  input fscc_pkg::in_word_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input fscc_pkg::out_word_t        out_data
);

  // one tick in flight: ready drops right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in flight");

  // auto release goes with auto status and never with a duty write
  a_auto_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.auto_write |-> out_data.in_auto && !out_data.duty_write)
    else $error("auto release with bad status or duty write");

  // no duty byte without a duty write
  a_duty_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.duty_write |-> out_data.duty_value == 8'd0)
    else $error("duty byte set without a duty write");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fan_speed_curve_controller_top fscc_checker u_fscc_checker (.*);
